// File: rtl/tlu_pkg.sv
// ----------------------------------------------------------------------------
// Tridiagonal LU factor sweep package
// Shared widths, limits, status codes and sequencer states of the block.
// ----------------------------------------------------------------------------
package tlu_pkg;

  localparam int DATA_W        = 48;
  localparam int HALF_W        = 24;
  localparam int PROD_W        = 96;
  localparam int WIDE_W        = 64;
  localparam int QUO_W         = 50;
  localparam int DEF_FRAC_BITS = 24;

  localparam logic signed [DATA_W-1:0] W48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DATA_W-1:0] W48_MIN = 48'sh8000_0000_0000;

  localparam logic [WIDE_W-1:0] WIDE_CAP     = 64'h4000_0000_0000_0000;
  localparam logic [WIDE_W-1:0] WIDE_NEG_CAP = 64'hC000_0000_0000_0000;

  localparam logic [QUO_W-1:0] QUO_CAP     = 50'h1_0000_0000_0000;
  localparam logic [QUO_W-1:0] QUO_SAT     = 50'h1_0000_0000_0001;
  localparam logic [QUO_W-1:0] QUO_POS_LIM = 50'h0_7FFF_FFFF_FFFF;
  localparam logic [QUO_W-1:0] QUO_NEG_LIM = 50'h0_8000_0000_0000;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SAT      = 2'd1,
    STAT_ZERO_DEN = 2'd2
  } tlu_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_T,
    S_ELIM,
    S_CHECK,
    S_DIV,
    S_PIVOT,
    S_MUL_C,
    S_DONE
  } tlu_state_t;

endpackage

// File: rtl/tlu_row_if.sv
// ----------------------------------------------------------------------------
// Row request channel
// Carries one tridiagonal matrix row per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlu_row_if import tlu_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     first_row;
  logic signed [DATA_W-1:0] sub_coef;
  logic signed [DATA_W-1:0] diag_coef;
  logic signed [DATA_W-1:0] super_coef;

  modport source (
    output valid, first_row, sub_coef, diag_coef, super_coef,
    input  ready
  );

  modport sink (
    input  valid, first_row, sub_coef, diag_coef, super_coef,
    output ready
  );

endinterface

// File: rtl/tlu_res_if.sv
// ----------------------------------------------------------------------------
// Factor result channel
// Carries the pivot, modified super-diagonal term and status of one row.
// ----------------------------------------------------------------------------
interface tlu_res_if import tlu_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pivot;
  logic signed [DATA_W-1:0] c_prime;
  logic [1:0]               status;

  modport source (
    output valid, pivot, c_prime, status,
    input  ready
  );

  modport sink (
    input  valid, pivot, c_prime, status,
    output ready
  );

endinterface

// File: rtl/tlu_mul_unit.sv
// ----------------------------------------------------------------------------
// Iterative magnitude multiplier
// Forms a 48 x 48 bit unsigned product from four 24 x 24 bit partial products,
// one per cycle, accumulated in a registered 96-bit sum.
// ----------------------------------------------------------------------------
module tlu_mul_unit import tlu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic                busy_r;
  logic                done_r;
  logic [2:0]          cnt_r;
  logic [DATA_W-1:0]   a_r;
  logic [DATA_W-1:0]   b_r;
  logic [DATA_W-1:0]   pp_r;
  logic [1:0]          sh_r;
  logic [PROD_W-1:0]   acc_r;

  logic [HALF_W-1:0]   a_half;
  logic [HALF_W-1:0]   b_half;
  logic [DATA_W-1:0]   pp_nxt;
  logic [1:0]          sh_nxt;
  logic [PROD_W-1:0]   acc_nxt;

  assign a_half = cnt_r[1] ? a_r[DATA_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign b_half = cnt_r[0] ? b_r[DATA_W-1:HALF_W] : b_r[HALF_W-1:0];
  assign pp_nxt = a_half * b_half;
  assign sh_nxt = 2'(cnt_r[1]) + 2'(cnt_r[0]);

  always_comb begin
    case (sh_r)
      2'd0:    acc_nxt = acc_r + {{(PROD_W-DATA_W){1'b0}}, pp_r};
      2'd1:    acc_nxt = acc_r + ({{(PROD_W-DATA_W){1'b0}}, pp_r} << HALF_W);
      default: acc_nxt = acc_r + ({{(PROD_W-DATA_W){1'b0}}, pp_r} << DATA_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != LAST_STEP) begin
        pp_r <= pp_nxt;
        sh_r <= sh_nxt;
      end
      if (cnt_r != 3'd0) begin
        acc_r <= acc_nxt;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: rtl/tlu_div_unit.sv
// ----------------------------------------------------------------------------
// Restoring reciprocal divider
// Computes floor(2^(2*FRAC_BITS) / d) one quotient bit per cycle. Once the
// quotient passes 2^48 it is held just above that limit.
// ----------------------------------------------------------------------------
module tlu_div_unit import tlu_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] d,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);

  localparam int                CNT_W   = $clog2(2 * FRAC_BITS + 1);
  localparam logic [CNT_W-1:0]  TOP_BIT = CNT_W'(2 * FRAC_BITS);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [WIDE_W-1:0]   d_r;
  logic [WIDE_W-1:0]   rem_r;
  logic [QUO_W-1:0]    q_r;

  logic [WIDE_W-1:0]   rem_sh;
  logic                ge;
  logic [WIDE_W-1:0]   rem_nxt;
  logic [QUO_W-1:0]    q_sh;
  logic [QUO_W-1:0]    q_nxt;

  always_comb begin
    rem_sh  = {rem_r[WIDE_W-2:0], (cnt_r == TOP_BIT)};
    ge      = (rem_sh >= d_r);
    rem_nxt = ge ? (rem_sh - d_r) : rem_sh;
    q_sh    = {q_r[QUO_W-2:0], ge};
    q_nxt   = (q_sh > QUO_CAP) ? QUO_SAT : q_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= TOP_BIT;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= d;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// File: rtl/tridiagonal_lu_factor_sweep.sv
// ----------------------------------------------------------------------------
// Tridiagonal LU factor sweep
// Forward factorization of the Thomas algorithm in signed fixed point.
// ----------------------------------------------------------------------------
// The row channel in_ch takes one matrix row per request: first_row, sub_coef,
// diag_coef and super_coef. The result channel out_ch returns one request per
// row with pivot = 1 / (diag - sub * prev_c_prime), c_prime = super * pivot
// and a status code (ok, saturated, zero denominator).
// One row is worked on at a time and in_ch.ready is high only while the
// sequencer is idle, so a new row is not accepted until the result of the
// last one has left S_DONE. A row passes the four-step partial-product
// multiplier for the elimination term, the one-bit-per-cycle reciprocal
// divider, and the multiplier again for c_prime. A first row skips the
// elimination multiply; a zero denominator skips the divider and the second
// multiply.
// A finished result sits in the output register while the next row is
// accepted; if the receiver stalls, the sequencer holds the following result
// until the output register is free.
// Synchronous reset clears the stored c_prime to zero and empties the output.
// ----------------------------------------------------------------------------
module tridiagonal_lu_factor_sweep import tlu_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  tlu_row_if.sink  in_ch,
  tlu_res_if.source out_ch
);

  localparam logic [PROD_W-1:0]      FRAC_MASK = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
  localparam logic signed [WIDE_W:0] NEG_CAP65 = -$signed({1'b0, WIDE_CAP});
  localparam logic signed [WIDE_W:0] MAX65     = (WIDE_W+1)'(W48_MAX);
  localparam logic signed [WIDE_W:0] MIN65     = (WIDE_W+1)'(W48_MIN);

  tlu_state_t               state_r, state_nxt;
  logic signed [DATA_W-1:0] diag_r, diag_nxt;
  logic signed [DATA_W-1:0] sup_r, sup_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [WIDE_W-1:0] t_r, t_nxt;
  logic signed [WIDE_W-1:0] den_r, den_nxt;
  logic signed [DATA_W-1:0] pivot_r, pivot_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [DATA_W-1:0] cp_r, cp_nxt;
  tlu_status_t              status_r, status_nxt;
  logic signed [DATA_W-1:0] prev_r, prev_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_pivot_r, out_pivot_nxt;
  logic signed [DATA_W-1:0] out_cp_r, out_cp_nxt;
  tlu_status_t              out_status_r, out_status_nxt;

  logic                     mul_start;
  logic [DATA_W-1:0]        mul_a;
  logic [DATA_W-1:0]        mul_b;
  logic                     mul_done;
  logic [PROD_W-1:0]        mul_prod;
  logic                     div_start;
  logic                     div_done;
  logic [QUO_W-1:0]         div_quo;
  logic [WIDE_W-1:0]        den_mag;
  logic signed [WIDE_W:0]   r_round;

  function automatic logic [DATA_W-1:0] mag48(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? (DATA_W'(0) - $unsigned(v)) : $unsigned(v);
  endfunction

  // Floor of the product divided by 2^FRAC_BITS, with the sign applied and
  // the magnitude capped at 2^62.
  function automatic logic signed [WIDE_W:0] round_q(input logic [PROD_W-1:0] prod,
                                                     input logic neg);
    logic [PROD_W-1:0] q;
    logic              frac;
    logic [WIDE_W:0]   r;
    q    = prod >> FRAC_BITS;
    frac = |(prod & FRAC_MASK);
    if (q > PROD_W'(WIDE_CAP)) begin
      r = neg ? ((WIDE_W+1)'(0) - {1'b0, WIDE_CAP}) : {1'b0, WIDE_CAP};
    end else if (neg) begin
      r = (WIDE_W+1)'(0) - {1'b0, q[WIDE_W-1:0]} - (WIDE_W+1)'(frac);
    end else begin
      r = {1'b0, q[WIDE_W-1:0]};
    end
    return $signed(r);
  endfunction

  assign den_mag = den_r[WIDE_W-1] ? (WIDE_W'(0) - $unsigned(den_r)) : $unsigned(den_r);
  assign r_round = round_q(mul_prod, neg_r);

  tlu_mul_unit u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tlu_div_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .d     (den_mag),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diag_r       <= diag_nxt;
    sup_r        <= sup_nxt;
    neg_r        <= neg_nxt;
    t_r          <= t_nxt;
    den_r        <= den_nxt;
    pivot_r      <= pivot_nxt;
    sat_r        <= sat_nxt;
    cp_r         <= cp_nxt;
    status_r     <= status_nxt;
    out_pivot_r  <= out_pivot_nxt;
    out_cp_r     <= out_cp_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    diag_nxt       = diag_r;
    sup_nxt        = sup_r;
    neg_nxt        = neg_r;
    t_nxt          = t_r;
    den_nxt        = den_r;
    pivot_nxt      = pivot_r;
    sat_nxt        = sat_r;
    cp_nxt         = cp_r;
    status_nxt     = status_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r;
    out_pivot_nxt  = out_pivot_r;
    out_cp_nxt     = out_cp_r;
    out_status_nxt = out_status_r;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          diag_nxt = in_ch.diag_coef;
          sup_nxt  = in_ch.super_coef;
          if (in_ch.first_row) begin
            t_nxt     = '0;
            state_nxt = S_ELIM;
          end else begin
            mul_start = 1'b1;
            mul_a     = mag48(in_ch.sub_coef);
            mul_b     = mag48(prev_r);
            neg_nxt   = in_ch.sub_coef[DATA_W-1] ^ prev_r[DATA_W-1];
            state_nxt = S_MUL_T;
          end
        end
      end
      S_MUL_T: begin
        if (mul_done) begin
          t_nxt     = (r_round < NEG_CAP65) ? $signed(WIDE_NEG_CAP) : r_round[WIDE_W-1:0];
          state_nxt = S_ELIM;
        end
      end
      S_ELIM: begin
        den_nxt   = WIDE_W'(diag_r) - t_r;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (den_r == '0) begin
          pivot_nxt  = W48_MAX;
          cp_nxt     = '0;
          status_nxt = STAT_ZERO_DEN;
          state_nxt  = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          sat_nxt = 1'b0;
          if (!den_r[WIDE_W-1]) begin
            if (div_quo > QUO_POS_LIM) begin
              pivot_nxt = W48_MAX;
              sat_nxt   = 1'b1;
            end else begin
              pivot_nxt = $signed(div_quo[DATA_W-1:0]);
            end
          end else begin
            if (div_quo > QUO_NEG_LIM) begin
              pivot_nxt = W48_MIN;
              sat_nxt   = 1'b1;
            end else begin
              pivot_nxt = $signed(DATA_W'(0) - div_quo[DATA_W-1:0]);
            end
          end
          state_nxt = S_PIVOT;
        end
      end
      S_PIVOT: begin
        mul_start = 1'b1;
        mul_a     = mag48(sup_r);
        mul_b     = mag48(pivot_r);
        neg_nxt   = sup_r[DATA_W-1] ^ pivot_r[DATA_W-1];
        state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        if (mul_done) begin
          if (r_round > MAX65) begin
            cp_nxt     = W48_MAX;
            status_nxt = STAT_SAT;
          end else if (r_round < MIN65) begin
            cp_nxt     = W48_MIN;
            status_nxt = STAT_SAT;
          end else begin
            cp_nxt     = r_round[DATA_W-1:0];
            status_nxt = sat_r ? STAT_SAT : STAT_OK;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_pivot_nxt  = pivot_r;
          out_cp_nxt     = cp_r;
          out_status_nxt = status_r;
          prev_nxt       = cp_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.pivot   = out_pivot_r;
  assign out_ch.c_prime = out_cp_r;
  assign out_ch.status  = out_status_r;

endmodule

// File: rtl/tlu_checker.sv
// ----------------------------------------------------------------------------
// Tridiagonal LU factor sweep checker
// Port-level assertions on the row and result channels, bound to the top.
// ----------------------------------------------------------------------------
module tlu_checker import tlu_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_pivot,
  input logic signed [DATA_W-1:0] out_c_prime,
  input logic [1:0]               out_status
);

  // The result channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pivot) &&
                               $stable(out_c_prime) && $stable(out_status))
    else $error("stalled result changed");

  // Once a row is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("row accepted back to back");

  // The status code never takes the unused value.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK) || (out_status == STAT_SAT) ||
                  (out_status == STAT_ZERO_DEN))
    else $error("unused status code");

  // A zero denominator reports the largest pivot and a zero c_prime.
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_ZERO_DEN) |->
      (out_pivot == W48_MAX) && (out_c_prime == '0))
    else $error("zero denominator result malformed");

endmodule

bind tridiagonal_lu_factor_sweep tlu_checker u_tlu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_pivot   (out_ch.pivot),
  .out_c_prime (out_ch.c_prime),
  .out_status  (out_ch.status)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tridiagonal LU factor sweep testbench
// Sends matrix rows through the row channel with random gaps and stalls the
// result channel at random. Every accepted row is run through a fixed-point
// model of the forward sweep, and each returned pivot, c_prime and status is
// compared with the oldest prediction. Directed rows cover the saturation,
// zero denominator and elimination clamp corners; random rows follow.
// ----------------------------------------------------------------------------
module testbench;
  import tlu_pkg::*;

  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int ROW_TARGET  = 800;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 150;

  localparam logic signed [DATA_W-1:0] ONE      = 48'sh00_0001_000000;
  localparam logic signed [WIDE_W-1:0] ELIM_CAP = $signed(WIDE_CAP);
  localparam logic signed [WIDE_W-1:0] CP_HI    = W48_MAX;
  localparam logic signed [WIDE_W-1:0] CP_LO    = W48_MIN;
  localparam logic [127:0] PIV_POS_LIM = 128'h7FFF_FFFF_FFFF;
  localparam logic [127:0] PIV_NEG_LIM = 128'h8000_0000_0000;

  typedef struct {
    logic                     first_row;
    logic signed [DATA_W-1:0] sub_coef;
    logic signed [DATA_W-1:0] diag_coef;
    logic signed [DATA_W-1:0] super_coef;
  } row_t;

  typedef struct {
    logic signed [DATA_W-1:0] pivot;
    logic signed [DATA_W-1:0] c_prime;
    tlu_status_t              status;
  } factor_t;

  logic clk = 1'b0;
  logic rst_n;

  tlu_row_if row_ch ();
  tlu_res_if res_ch ();

  tridiagonal_lu_factor_sweep dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (row_ch),
    .out_ch (res_ch)
  );

  always #6 clk = ~clk;

  row_t                     rows_pending[$];
  factor_t                  factors_due[$];
  row_t                     row_on_bus;
  logic signed [DATA_W-1:0] last_c_prime;
  int                       error_count;
  int                       result_count;
  int                       cycle_count;
  int                       row_gap;
  int                       res_stall;
  int                       calm_left;

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    $display("testbench: result %0d %s got %h want %h", result_count, what, got, want);
    error_count++;
  endtask

  // Floor of a*b / 2^FRAC, clamped to [lo, hi].
  function automatic logic signed [WIDE_W-1:0] fx_mul(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    input  logic signed [WIDE_W-1:0] lo,
    input  logic signed [WIDE_W-1:0] hi,
    output logic                     clamped
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] q;
    prod    = a * b;
    q       = prod >>> FRAC;
    clamped = 1'b0;
    if (q > hi) begin
      q       = hi;
      clamped = 1'b1;
    end else if (q < lo) begin
      q       = lo;
      clamped = 1'b1;
    end
    return q[WIDE_W-1:0];
  endfunction

  function automatic factor_t factor_row(input row_t r);
    logic signed [WIDE_W-1:0] elim;
    logic signed [WIDE_W-1:0] den;
    logic signed [WIDE_W-1:0] cp;
    logic [127:0]             dmag;
    logic [127:0]             quo;
    logic signed [DATA_W-1:0] piv;
    logic                     sat;
    logic                     hit;
    factor_t                  f;
    sat  = 1'b0;
    elim = '0;
    if (!r.first_row) begin
      elim = fx_mul(r.sub_coef, last_c_prime, -ELIM_CAP, ELIM_CAP, hit);
    end
    den = r.diag_coef;
    den = den - elim;
    if (den == 0) begin
      f.pivot   = W48_MAX;
      f.c_prime = '0;
      f.status  = STAT_ZERO_DEN;
    end else begin
      dmag = (den < 0) ? 128'(-den) : 128'(den);
      quo  = (128'd1 << (2 * FRAC)) / dmag;
      if (den > 0) begin
        if (quo > PIV_POS_LIM) begin
          piv = W48_MAX;
          sat = 1'b1;
        end else begin
          piv = quo[DATA_W-1:0];
        end
      end else begin
        if (quo > PIV_NEG_LIM) begin
          piv = W48_MIN;
          sat = 1'b1;
        end else begin
          piv = -quo[DATA_W-1:0];
        end
      end
      cp        = fx_mul(r.super_coef, piv, CP_LO, CP_HI, hit);
      f.pivot   = piv;
      f.c_prime = cp[DATA_W-1:0];
      f.status  = (sat || hit) ? STAT_SAT : STAT_OK;
    end
    last_c_prime = f.c_prime;
    return f;
  endfunction

  task automatic add_row(input logic first, input logic signed [DATA_W-1:0] s,
                         input logic signed [DATA_W-1:0] d,
                         input logic signed [DATA_W-1:0] u);
    row_t r;
    r.first_row  = first;
    r.sub_coef   = s;
    r.diag_coef  = d;
    r.super_coef = u;
    rows_pending.push_back(r);
  endtask

  // Random value with nbits significant bits, sign extended to the full width.
  function automatic logic signed [DATA_W-1:0] rand_span(input int nbits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return $signed(r[DATA_W-1:0] << (DATA_W - nbits)) >>> (DATA_W - nbits);
  endfunction

  function automatic logic signed [DATA_W-1:0] any_coef();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_span(DATA_W);
      4, 5:       return rand_span($urandom_range(2, 40));
      6:          return rand_span(3);
      7:          return rand_span(5) <<< FRAC;
      8: begin
        case ($urandom_range(0, 5))
          0:       return W48_MAX;
          1:       return W48_MIN;
          2:       return ONE;
          3:       return -ONE;
          4:       return 48'sd1;
          default: return -48'sd1;
        endcase
      end
      default:    return '0;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      row_ch.valid <= 1'b0;
      row_gap      = 0;
      last_c_prime = '0;
    end else begin
      if (row_ch.valid && row_ch.ready) begin
        factors_due.push_back(factor_row(row_on_bus));
      end
      if (!(row_ch.valid && !row_ch.ready)) begin
        if (row_gap > 0) begin
          row_gap--;
          row_ch.valid <= 1'b0;
        end else if (rows_pending.size() != 0) begin
          row_on_bus           = rows_pending.pop_front();
          row_ch.first_row  <= row_on_bus.first_row;
          row_ch.sub_coef   <= row_on_bus.sub_coef;
          row_ch.diag_coef  <= row_on_bus.diag_coef;
          row_ch.super_coef <= row_on_bus.super_coef;
          row_ch.valid      <= 1'b1;
          row_gap = pick_gap();
        end else begin
          row_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      res_stall    = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (factors_due.size() == 0) begin
          report("unexpected", res_ch.pivot, '0);
        end else begin
          factor_t want;
          want = factors_due.pop_front();
          if (res_ch.pivot !== want.pivot) report("pivot", res_ch.pivot, want.pivot);
          if (res_ch.c_prime !== want.c_prime) begin
            report("c_prime", res_ch.c_prime, want.c_prime);
          end
          if (res_ch.status !== want.status) begin
            report("status", DATA_W'(res_ch.status), DATA_W'(want.status));
          end
        end
        result_count++;
      end
      if (res_stall > 0) begin
        res_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) res_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int   rows;
    logic shaped;
    logic first;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] d;
    logic signed [DATA_W-1:0] u;

    rst_n             = 1'b0;
    row_ch.valid      = 1'b0;
    row_ch.first_row  = 1'b0;
    row_ch.sub_coef   = '0;
    row_ch.diag_coef  = '0;
    row_ch.super_coef = '0;
    res_ch.ready      = 1'b0;
    error_count       = 0;
    result_count      = 0;
    cycle_count       = 0;
    calm_left         = 0;
    last_c_prime      = '0;

    // A first row ignores its sub term; an equal sub and diag then cancel.
    add_row(1'b1, W48_MAX, ONE, ONE);
    add_row(1'b0, 5 * ONE, 5 * ONE, ONE);
    add_row(1'b0, W48_MIN, 2 * ONE, W48_MAX);
    add_row(1'b1, '0, '0, '0);
    // Tiny diagonals saturate the pivot; the products saturate c_prime.
    add_row(1'b1, W48_MIN, 48'sd1, W48_MAX);
    add_row(1'b0, W48_MIN, W48_MAX, W48_MIN);
    add_row(1'b1, '0, -48'sd1, ONE);
    add_row(1'b0, W48_MIN, ONE, ONE);
    add_row(1'b1, '0, -48'sd2, -ONE);
    add_row(1'b1, '0, W48_MIN, W48_MIN);
    add_row(1'b1, '0, W48_MAX, W48_MAX);
    add_row(1'b1, '0, 3 * ONE, -ONE);
    add_row(1'b0, -ONE, 4 * ONE, ONE);
    add_row(1'b0, ONE, -3 * ONE, 2 * ONE);
    add_row(1'b0, -(ONE + ONE / 2), 5 * ONE + 123, -ONE);
    add_row(1'b1, '0, 48'sd1, '0);
    add_row(1'b1, '0, 48'sd2, '0);
    add_row(1'b1, '0, 48'sd3, '0);
    add_row(1'b1, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555);
    add_row(1'b0, 48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA);
    add_row(1'b1, '0, -ONE, ONE);
    add_row(1'b0, 3 * ONE, -3 * ONE, ONE);
    add_row(1'b0, W48_MAX, -ONE, W48_MAX);

    while (rows_pending.size() < ROW_TARGET) begin
      rows   = $urandom_range(1, 12);
      shaped = ($urandom_range(0, 99) < 75);
      for (int i = 0; i < rows; i++) begin
        if (shaped) begin
          s     = rand_span(27);
          u     = rand_span(27);
          d     = rand_span(25) + ($urandom_range(0, 1) ? 6 * ONE : -6 * ONE);
          first = (i == 0);
        end else begin
          s     = any_coef();
          d     = any_coef();
          u     = any_coef();
          first = (i == 0) ? 1'b1 : ($urandom_range(0, 9) == 0);
        end
        add_row(first, s, d, u);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (rows_pending.size() != 0 || row_ch.valid) @(posedge clk);
    while (factors_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
